>>> hw/rtl/positional_list_with_sort_top_defines.svh
// Assertion macros for the positional list
`ifndef POSITIONAL_LIST_WITH_SORT_TOP_DEFINES_SVH
`define POSITIONAL_LIST_WITH_SORT_TOP_DEFINES_SVH

// same-cycle implication
`define PLS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PLS_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/pls_pkg.sv
`timescale 1ns / 1ps
package pls_pkg;

    localparam logic [2:0] OP_INSERT  = 3'd0;
    localparam logic [2:0] OP_REMOVE  = 3'd1;
    localparam logic [2:0] OP_READ    = 3'd2;
    localparam logic [2:0] OP_REPLACE = 3'd3;
    localparam logic [2:0] OP_CLEAR   = 3'd4;
    localparam logic [2:0] OP_SORT    = 3'd5;

    typedef enum logic [2:0] {
        ACT_HOLD,
        ACT_INS,
        ACT_REM,
        ACT_WR,
        ACT_SORT
    } t_act;

    typedef struct packed {
        t_act act;
        logic odd;
    } t_cell_ctl;

endpackage

>>> hw/rtl/pls_cell.sv
`timescale 1ns / 1ps
module pls_cell import pls_pkg::*; #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 16,
    parameter int IDX        = 0
) (
    input  logic                          i_clk,
    input  t_cell_ctl                     i_ctl,
    input  logic [$clog2(CAPACITY+2)-1:0] i_pidx,
    input  logic [$clog2(CAPACITY+1)-1:0] i_held,
    input  logic [DATA_WIDTH-1:0]         i_value,
    input  logic [DATA_WIDTH-1:0]         i_left,
    input  logic [DATA_WIDTH-1:0]         i_right,
    input  logic                          i_swap_left,
    output logic [DATA_WIDTH-1:0]         o_data,
    output logic [DATA_WIDTH-1:0]         o_rd,
    output logic                          o_swap_right
);

    localparam int PW = $clog2(CAPACITY + 2);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [PW-1:0] MY_IDX  = PW'(IDX);
    localparam logic [CW-1:0] MY_NEXT = CW'(IDX + 1);
    localparam logic          MY_ODD  = 1'(IDX % 2);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    // odd-even transposition: this cell owns the pair with its right neighbor
    assign o_swap_right = (i_ctl.act == ACT_SORT) && (i_ctl.odd == MY_ODD) &&
                          (MY_NEXT < i_held) && (r_data > i_right);

    always_comb begin
        n_data = r_data;
        case (i_ctl.act)
            ACT_INS: begin
                if (MY_IDX == i_pidx) begin
                    n_data = i_value;
                end else if (MY_IDX > i_pidx) begin
                    n_data = i_left;
                end
            end
            ACT_REM: begin
                if (MY_IDX >= i_pidx) begin
                    n_data = i_right;
                end
            end
            ACT_WR: begin
                if (MY_IDX == i_pidx) begin
                    n_data = i_value;
                end
            end
            ACT_SORT: begin
                if (o_swap_right) begin
                    n_data = i_right;
                end else if (i_swap_left) begin
                    n_data = i_left;
                end
            end
            default: begin
                n_data = r_data;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;
    assign o_rd   = (MY_IDX == i_pidx) ? r_data : '0;

endmodule

>>> hw/rtl/positional_list_with_sort_top.sv
`timescale 1ns / 1ps
// Positional list with sort: up to CAPACITY entries at 1-based positions.
// Command channel: drive i_op, i_position, i_value with start high; the item
// is taken at a rising edge where start is high and busy is low.
// Ops: insert, remove, read, replace, clear, sort (see pls_pkg op codes).
// Result channel: o_done is high for exactly one cycle with o_ok, o_data_out,
// o_count and o_empty_res. The receiver cannot stall; it must take the
// result in that cycle.
// Insert, remove, read, replace, clear and unused codes answer in the cycle
// after acceptance and busy stays low, so one item per cycle while no sort runs.
// Sort runs CAPACITY odd-even compare/swap phases over the row of cells,
// one phase per cycle; busy stays high while the phases run and the result
// appears in the cycle busy falls.
// Each cell holds one entry and trades with its neighbors, so shifts for
// insert and remove move the whole row together.
// Reset (i_rst_n low, synchronous) empties the list and returns to idle;
// entry contents are not cleared and are never read before being written.
module positional_list_with_sort_top import pls_pkg::*; #(
    parameter int CAPACITY   = 64,
    parameter int DATA_WIDTH = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    i_op,
    input  logic [$clog2(CAPACITY+2)-1:0] i_position,
    input  logic [DATA_WIDTH-1:0]         i_value,
    output logic                          o_done,
    output logic                          o_ok,
    output logic [DATA_WIDTH-1:0]         o_data_out,
    output logic [$clog2(CAPACITY+1)-1:0] o_count,
    output logic                          o_empty_res
);

`include "positional_list_with_sort_top_defines.svh"

    localparam int PW  = $clog2(CAPACITY + 2);
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int PHW = $clog2(CAPACITY);
    localparam logic [PHW-1:0] LAST_PHASE = PHW'(CAPACITY - 1);
    localparam logic [CW-1:0]  CAP_CNT    = CW'(CAPACITY);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SORT = 2'b10
    } t_state;

    t_state                r_state, n_state;
    logic [CW-1:0]         r_held, n_held;
    logic [PHW-1:0]        r_phase, n_phase;
    logic                  r_done, n_done;
    logic                  r_ok, n_ok;
    logic [DATA_WIDTH-1:0] r_data, n_data;

    t_cell_ctl             w_ctl;
    logic                  w_accept;
    logic [PW-1:0]         w_pidx;
    logic [PW-1:0]         w_held_p;
    logic                  w_ins_ok;
    logic                  w_pos_ok;
    logic [DATA_WIDTH-1:0] w_rd_any;

    logic [DATA_WIDTH-1:0] w_data  [CAPACITY];
    logic [DATA_WIDTH-1:0] w_rd    [CAPACITY];
    logic [DATA_WIDTH-1:0] w_left  [CAPACITY];
    logic [DATA_WIDTH-1:0] w_right [CAPACITY];
    logic                  w_swap  [CAPACITY];
    logic                  w_swap_left [CAPACITY];

    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;
    assign w_pidx   = i_position - PW'(1);
    assign w_held_p = PW'(r_held);
    assign w_pos_ok = (i_position != '0) && (i_position <= w_held_p);
    assign w_ins_ok = (i_position != '0) && (i_position <= w_held_p + PW'(1)) &&
                      (r_held < CAP_CNT);

    always_comb begin
        w_ctl.odd = r_phase[0];
        w_ctl.act = ACT_HOLD;
        if (r_state == ST_SORT) begin
            w_ctl.act = ACT_SORT;
        end else if (w_accept) begin
            unique case (i_op)
                OP_INSERT:  w_ctl.act = w_ins_ok ? ACT_INS : ACT_HOLD;
                OP_REMOVE:  w_ctl.act = w_pos_ok ? ACT_REM : ACT_HOLD;
                OP_REPLACE: w_ctl.act = w_pos_ok ? ACT_WR  : ACT_HOLD;
                default:    w_ctl.act = ACT_HOLD;
            endcase
        end
    end

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_left[g]      = '0;
            assign w_swap_left[g] = 1'b0;
        end else begin : g_mid
            assign w_left[g]      = w_data[g-1];
            assign w_swap_left[g] = w_swap[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_right[g] = '0;
        end else begin : g_inner
            assign w_right[g] = w_data[g+1];
        end

        pls_cell #(
            .CAPACITY   (CAPACITY),
            .DATA_WIDTH (DATA_WIDTH),
            .IDX        (g)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_pidx       (w_pidx),
            .i_held       (r_held),
            .i_value      (i_value),
            .i_left       (w_left[g]),
            .i_right      (w_right[g]),
            .i_swap_left  (w_swap_left[g]),
            .o_data       (w_data[g]),
            .o_rd         (w_rd[g]),
            .o_swap_right (w_swap[g])
        );
    end

    always_comb begin
        w_rd_any = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_rd_any = w_rd_any | w_rd[k];
        end
    end

    always_comb begin
        n_state = r_state;
        n_held  = r_held;
        n_phase = r_phase;
        n_done  = 1'b0;
        n_ok    = r_ok;
        n_data  = r_data;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_done = 1'b1;
                    n_ok   = 1'b0;
                    n_data = '0;
                    unique case (i_op) inside
                        OP_INSERT: begin
                            n_ok = w_ins_ok;
                            if (w_ins_ok) begin
                                n_held = r_held + CW'(1);
                            end
                        end
                        OP_REMOVE: begin
                            n_ok = w_pos_ok;
                            if (w_pos_ok) begin
                                n_held = r_held - CW'(1);
                            end
                        end
                        OP_READ, OP_REPLACE: begin
                            n_ok   = w_pos_ok;
                            n_data = w_pos_ok ? w_rd_any : '0;
                        end
                        OP_CLEAR: begin
                            n_ok   = 1'b1;
                            n_held = '0;
                        end
                        OP_SORT: begin
                            n_done  = 1'b0;
                            n_phase = '0;
                            n_state = ST_SORT;
                        end
                        default: begin
                            n_ok = 1'b0;
                        end
                    endcase
                end
            end
            ST_SORT: begin
                n_phase = r_phase + PHW'(1);
                if (r_phase == LAST_PHASE) begin
                    n_state = ST_IDLE;
                    n_done  = 1'b1;
                    n_ok    = 1'b1;
                    n_data  = '0;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_held  <= '0;
            r_phase <= '0;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_held  <= n_held;
            r_phase <= n_phase;
            r_done  <= n_done;
        end
        r_ok   <= n_ok;
        r_data <= n_data;
    end

    assign o_done      = r_done;
    assign o_ok        = r_ok;
    assign o_data_out  = r_data;
    assign o_count     = r_held;
    assign o_empty_res = (r_held == '0);

    `PLS_ASSERT_NXT(a_quick_done, w_accept && (i_op != OP_SORT), o_done,
                    "non-sort item gave no result next cycle")
    `PLS_ASSERT_NXT(a_sort_busy, w_accept && (i_op == OP_SORT), busy && !o_done,
                    "sort did not hold busy")
    `PLS_ASSERT_NOW(a_done_idle, o_done, !busy,
                    "result shown while busy")
    `PLS_ASSERT_NXT(a_count_hold, !w_accept, $stable(o_count),
                    "count moved without an item")

endmodule

>>> bench/positional_list_with_sort_top_tb.sv
`timescale 1ns / 1ps
module positional_list_with_sort_top_tb import pls_pkg::*;;

    localparam int CAP          = 64;
    localparam int DW           = 16;
    localparam int POS_W        = $clog2(CAP + 2);
    localparam int CNT_W        = $clog2(CAP + 1);
    localparam int RANDOM_ITEMS = 1377;
    localparam int IDLE_LIMIT   = 2000;
    localparam int DRAIN_CYCLES = CAP + 4;

    localparam logic [2:0] OP_RSVD6 = 3'd6;
    localparam logic [2:0] OP_RSVD7 = 3'd7;

    localparam int MODE_FILL  = 0;
    localparam int MODE_DRAIN = 1;
    localparam int MODE_MIX   = 2;

    localparam logic [POS_W-1:0] POS_MAX = POS_W'(2**POS_W - 1);

    typedef struct packed {
        logic             ok;
        logic [DW-1:0]    data;
        logic [CNT_W-1:0] count;
        logic             empty;
    } t_list_resp;

    logic             i_clk;
    logic             i_rst_n    = 1'b0;
    logic             start      = 1'b0;
    logic             busy;
    logic [2:0]       i_op       = '0;
    logic [POS_W-1:0] i_position = '0;
    logic [DW-1:0]    i_value    = '0;
    logic             o_done;
    logic             o_ok;
    logic [DW-1:0]    o_data_out;
    logic [CNT_W-1:0] o_count;
    logic             o_empty_res;

    logic [DW-1:0] list_mem [CAP];
    int            list_len = 0;
    t_list_resp    pending_resp [$];

    int err_count    = 0;
    int resp_checked = 0;
    int n_refused    = 0;
    int peak_len     = 0;
    int idle_cycles  = 0;
    int op_seen [8];

    positional_list_with_sort_top #(
        .CAPACITY   (CAP),
        .DATA_WIDTH (DW)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_op        (i_op),
        .i_position  (i_position),
        .i_value     (i_value),
        .o_done      (o_done),
        .o_ok        (o_ok),
        .o_data_out  (o_data_out),
        .o_count     (o_count),
        .o_empty_res (o_empty_res)
    );

    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    function automatic logic [DW-1:0] rand_val();
        return DW'($urandom);
    endfunction

    function automatic t_list_resp apply_request(logic [2:0] op, logic [POS_W-1:0] pos,
                                                 logic [DW-1:0] val);
        t_list_resp    r;
        int            p;
        int            j;
        logic [DW-1:0] key;
        r = '0;
        p = int'(pos);
        case (op)
            OP_INSERT: begin
                if (p >= 1 && p <= list_len + 1 && list_len < CAP) begin
                    for (int k = list_len; k >= p; k--)
                        list_mem[k] = list_mem[k-1];
                    list_mem[p-1] = val;
                    list_len++;
                    r.ok = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (p >= 1 && p <= list_len) begin
                    for (int k = p; k < list_len; k++)
                        list_mem[k-1] = list_mem[k];
                    list_len--;
                    r.ok = 1'b1;
                end
            end
            OP_READ: begin
                if (p >= 1 && p <= list_len) begin
                    r.data = list_mem[p-1];
                    r.ok   = 1'b1;
                end
            end
            OP_REPLACE: begin
                if (p >= 1 && p <= list_len) begin
                    r.data        = list_mem[p-1];
                    list_mem[p-1] = val;
                    r.ok          = 1'b1;
                end
            end
            OP_CLEAR: begin
                list_len = 0;
                r.ok     = 1'b1;
            end
            OP_SORT: begin
                for (int i = 1; i < list_len; i++) begin
                    key = list_mem[i];
                    j   = i;
                    while (j > 0 && list_mem[j-1] > key) begin
                        list_mem[j] = list_mem[j-1];
                        j--;
                    end
                    list_mem[j] = key;
                end
                r.ok = 1'b1;
            end
            default: ;
        endcase
        r.count = CNT_W'(list_len);
        r.empty = (list_len == 0);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99, 0);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(3, 1);
        else if (r < 97)
            return $urandom_range(10, 4);
        else
            return $urandom_range(40, 20);
    endfunction

    function automatic logic [POS_W-1:0] pick_position(logic [2:0] op);
        int top;
        top = (op == OP_INSERT) ? list_len + 1 : list_len;
        if (top >= 1 && $urandom_range(99, 0) < 85)
            return POS_W'($urandom_range(top, 1));
        case ($urandom_range(3, 0))
            0:       return '0;
            1:       return POS_W'(top + 1);
            2:       return POS_W'(top + 1 + $urandom_range(3, 0));
            default: return POS_W'($urandom_range(2**POS_W - 1, 0));
        endcase
    endfunction

    function automatic logic [2:0] pick_op(int mode);
        int r;
        r = $urandom_range(99, 0);
        case (mode)
            MODE_FILL: begin
                if (r < 75) return OP_INSERT;
                if (r < 83) return OP_READ;
                if (r < 90) return OP_REPLACE;
                if (r < 95) return OP_REMOVE;
                if (r < 97) return OP_SORT;
                if (r < 98) return OP_CLEAR;
            end
            MODE_DRAIN: begin
                if (r < 15) return OP_INSERT;
                if (r < 70) return OP_REMOVE;
                if (r < 80) return OP_READ;
                if (r < 88) return OP_REPLACE;
                if (r < 93) return OP_SORT;
                if (r < 95) return OP_CLEAR;
            end
            default: begin
                if (r < 30) return OP_INSERT;
                if (r < 55) return OP_REMOVE;
                if (r < 72) return OP_READ;
                if (r < 87) return OP_REPLACE;
                if (r < 91) return OP_SORT;
                if (r < 93) return OP_CLEAR;
            end
        endcase
        return $urandom_range(1, 0) ? OP_RSVD6 : OP_RSVD7;
    endfunction

    task automatic send_request(logic [2:0] op, logic [POS_W-1:0] pos, logic [DW-1:0] val,
                                bit no_gaps = 1'b0);
        t_list_resp r;
        int         gap;
        i_op       <= op;
        i_position <= pos;
        i_value    <= val;
        start      <= 1'b1;
        do
            @(posedge i_clk);
        while (busy !== 1'b0);
        r = apply_request(op, pos, val);
        pending_resp.push_back(r);
        op_seen[op]++;
        if (!r.ok)
            n_refused++;
        if (list_len > peak_len)
            peak_len = list_len;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic test_empty_list();
        send_request(OP_REMOVE, 1, rand_val());
        send_request(OP_READ, 1, rand_val());
        send_request(OP_REPLACE, 1, 16'hFFFF);
        send_request(OP_INSERT, 0, 16'hFFFF);
        send_request(OP_INSERT, 2, 16'h0001);
        send_request(OP_SORT, 0, rand_val());
        send_request(OP_CLEAR, 5, rand_val());
        send_request(OP_RSVD6, 1, rand_val());
        send_request(OP_RSVD7, 0, 16'hFFFF);
    endtask

    task automatic test_edge_positions();
        send_request(OP_INSERT, 1, 16'hFFFF);
        send_request(OP_INSERT, 1, 16'h0000);
        send_request(OP_INSERT, 3, 16'h8000);
        send_request(OP_INSERT, 5, 16'h1111);
        send_request(OP_READ, 1, rand_val());
        send_request(OP_READ, 3, rand_val());
        send_request(OP_READ, 4, rand_val());
        send_request(OP_REPLACE, 3, 16'h1234);
        send_request(OP_REMOVE, 2, rand_val());
        send_request(OP_SORT, 1, rand_val());
        send_request(OP_READ, 1, rand_val());
        send_request(OP_READ, 2, rand_val());
        send_request(OP_REMOVE, 0, rand_val());
        send_request(OP_READ, POS_MAX, rand_val());
        send_request(OP_CLEAR, POS_MAX, rand_val());
    endtask

    task automatic test_random_traffic();
        int         sent;
        int         mode;
        int         block_len;
        bit         burst;
        logic [2:0] op;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            mode      = $urandom_range(MODE_MIX, MODE_FILL);
            block_len = $urandom_range(120, 30);
            burst     = ($urandom_range(3, 0) == 0);
            for (int i = 0; i < block_len && sent < RANDOM_ITEMS; i++) begin
                op = pick_op(mode);
                send_request(op, pick_position(op), rand_val(), burst);
                sent++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_list_resp e;
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_resp.size() == 0) begin
                $error("result with nothing outstanding");
                err_count++;
            end else begin
                e = pending_resp.pop_front();
                resp_checked++;
                if (o_ok !== e.ok) begin
                    $error("ok: expected %0d, got %0d", e.ok, o_ok);
                    err_count++;
                end
                if (o_data_out !== e.data) begin
                    $error("data_out: expected %0h, got %0h", e.data, o_data_out);
                    err_count++;
                end
                if (o_count !== e.count) begin
                    $error("count: expected %0d, got %0d", e.count, o_count);
                    err_count++;
                end
                if (o_empty_res !== e.empty) begin
                    $error("empty_res: expected %0d, got %0d", e.empty, o_empty_res);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_done === 1'b1) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_list();
        test_edge_positions();
        test_random_traffic();
        start <= 1'b0;

        while (pending_resp.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_resp.size() != 0) begin
            $error("%0d results never arrived", pending_resp.size());
            err_count++;
        end

        $display("Sent %0d insert, %0d remove, %0d read, %0d replace, %0d clear, %0d sort",
                 op_seen[OP_INSERT], op_seen[OP_REMOVE], op_seen[OP_READ],
                 op_seen[OP_REPLACE], op_seen[OP_CLEAR], op_seen[OP_SORT]);
        $display("%0d unused, %0d checked, %0d refused, list reached %0d of %0d entries",
                 op_seen[OP_RSVD6] + op_seen[OP_RSVD7], resp_checked, n_refused,
                 peak_len, CAP);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
